// ----- rtl/tptp_pkg.sv -----
// Package for the tunnel policy tag parser.
// Holds the status codes, the result type and the frame layout constants.
// No dependencies.
package tptp_pkg;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_BAD_ETYPE = 3'd2,
        ST_BAD_HDR   = 3'd3,
        ST_BAD_PROTO = 3'd4,
        ST_NO_TAG    = 3'd5
    } t_status;

    typedef struct packed {
        logic       tag_found;
        logic [6:0] rule_id;
        t_status    status;
    } t_result;

    localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6   = 16'h86DD;
    localparam logic [7:0]  PROTO_MARK   = 8'd99;

    // Byte positions within the frame
    localparam int unsigned POS_ETYPE_HI = 12;
    localparam int unsigned POS_ETYPE_LO = 13;
    localparam int unsigned ETH_HDR      = 14;
    localparam int unsigned POS_V4_PROTO = ETH_HDR + 9;
    localparam int unsigned POS_V6_PROTO = ETH_HDR + 6;
    localparam int unsigned IPV6_HDR     = 40;
    localparam int unsigned MIN_FRAME    = ETH_HDR + 20;

    localparam logic [3:0] IHL_MIN       = 4'd5;
    localparam logic [6:0] NONCE_RESET   = 7'd16;

endpackage

// ----- rtl/tptp_frame_state.sv -----
// Frame state tracker for the tunnel policy tag parser.
// Updates the per-frame header state for one byte and forms the result on the last byte.
// Depends on tptp_pkg.
module tptp_frame_state #(
    parameter int COUNT_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  logic [7:0]         i_byte,
    input  logic               i_last,
    input  logic [6:0]         i_nonce,
    output tptp_pkg::t_result  o_result
);
    import tptp_pkg::*;

    logic [COUNT_BITS-1:0] r_count;
    logic [15:0]           r_etype;
    logic [3:0]            r_ihl;
    logic [7:0]            r_proto;
    logic [6:0]            r_tag;
    logic                  r_tag_seen;

    logic [COUNT_BITS-1:0] n_count;
    logic [15:0]           n_etype;
    logic [3:0]            n_ihl;
    logic [7:0]            n_proto;
    logic [6:0]            n_tag;
    logic                  n_tag_seen;

    logic                  is_v4;
    logic                  is_v6;
    logic [7:0]            hdr_end;
    logic [7:0]            tag_off;
    logic                  past_ihl;
    t_status               status;

    always_comb begin
        n_etype = r_etype;
        if (r_count == COUNT_BITS'(POS_ETYPE_HI)) begin
            n_etype[15:8] = i_byte;
        end else if (r_count == COUNT_BITS'(POS_ETYPE_LO)) begin
            n_etype[7:0] = i_byte;
        end

        n_ihl = (r_count == COUNT_BITS'(ETH_HDR)) ? i_byte[3:0] : r_ihl;

        is_v4 = (n_etype == ETYPE_IPV4);
        is_v6 = (n_etype == ETYPE_IPV6);

        n_proto = r_proto;
        if ((is_v4 && r_count == COUNT_BITS'(POS_V4_PROTO)) ||
            (is_v6 && r_count == COUNT_BITS'(POS_V6_PROTO))) begin
            n_proto = i_byte;
        end

        // End of the IP header; the tag follows after the nonce
        hdr_end = is_v4 ? (8'(ETH_HDR) + {2'b00, n_ihl, 2'b00})
                        : 8'(ETH_HDR + IPV6_HDR);
        tag_off = hdr_end + {1'b0, i_nonce};
        past_ihl = r_count > COUNT_BITS'(ETH_HDR);

        n_tag      = r_tag;
        n_tag_seen = r_tag_seen;
        if ((is_v4 || is_v6) && past_ihl && !r_tag_seen &&
            r_count == COUNT_BITS'(tag_off)) begin
            n_tag      = i_byte[6:0];
            n_tag_seen = 1'b1;
        end

        // Saturate at the top count
        n_count = (r_count == '1) ? r_count : r_count + COUNT_BITS'(1);

        // Checks in priority order; frame length is r_count + 1
        if (r_count < COUNT_BITS'(MIN_FRAME - 1)) begin
            status = ST_SHORT;
        end else if (!is_v4 && !is_v6) begin
            status = ST_BAD_ETYPE;
        end else if (is_v4 && (n_ihl < IHL_MIN || r_count < COUNT_BITS'(hdr_end))) begin
            status = ST_BAD_HDR;
        end else if (is_v6 && r_count < COUNT_BITS'(hdr_end)) begin
            status = ST_BAD_HDR;
        end else if (n_proto != PROTO_MARK) begin
            status = ST_BAD_PROTO;
        end else if (!n_tag_seen) begin
            status = ST_NO_TAG;
        end else begin
            status = ST_OK;
        end

        o_result.status    = status;
        o_result.tag_found = (status == ST_OK);
        o_result.rule_id   = (status == ST_OK) ? n_tag : 7'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_etype    <= '0;
            r_ihl      <= '0;
            r_proto    <= '0;
            r_tag      <= '0;
            r_tag_seen <= 1'b0;
        end else if (i_advance) begin
            if (i_last) begin
                // Clear for the next frame
                r_count    <= '0;
                r_etype    <= '0;
                r_ihl      <= '0;
                r_proto    <= '0;
                r_tag      <= '0;
                r_tag_seen <= 1'b0;
            end else begin
                r_count    <= n_count;
                r_etype    <= n_etype;
                r_ihl      <= n_ihl;
                r_proto    <= n_proto;
                r_tag      <= n_tag;
                r_tag_seen <= n_tag_seen;
            end
        end
    end

endmodule

// ----- rtl/tunnel_policy_tag_parser_unit.sv -----
// Top level of the tunnel policy tag parser.
// Holds the input and result registers, the handshakes and the nonce register.
// Depends on tptp_pkg and tptp_frame_state.
// Usage:
//   Input: one frame byte per item (i_data_byte), i_last_byte on the final byte,
//   taken at an edge where i_valid is high and o_stall is low. Bytes count from 0
//   after reset and after each last byte.
//   Output: one result per frame, for the last byte only (o_tag_found, o_rule_id,
//   o_status), taken at an edge where o_valid is high and i_stall is low.
//   Config: i_cfg_data sets the nonce length in bytes, written when i_cfg_valid
//   and o_cfg_ready are high. o_cfg_ready is always high; write only when no item is held.
// Timing:
//   One item per cycle sustained while o_stall is low. A last byte passes through
//   the input register, then its result is loaded into the result register.
// Stall:
//   A held result keeps its value while i_stall is high. Non-last bytes keep
//   flowing; a last byte waits in the input register, which raises o_stall.
// Reset:
//   Synchronous, active low. Clears frame state and both valid flags and sets
//   the nonce length to 16.
module tunnel_policy_tag_parser_unit #(
    parameter int COUNT_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Byte input
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_last_byte,
    // Result output
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_tag_found,
    output logic [6:0]            o_rule_id,
    output logic [2:0]            o_status,
    // Nonce length register
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [6:0]            i_cfg_data
);
    import tptp_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic [6:0] r_nonce;
    logic       r_out_valid;
    t_result    r_out;

    t_result    result;
    logic       advance;
    logic       in_take;

    // Advance the held byte unless it is a last byte blocked by a held result
    assign advance = r_in_valid && (!r_in_last || !r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign in_take = i_valid && !o_stall;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nonce <= NONCE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_nonce <= i_cfg_data;
        end
    end

    tptp_frame_state #(
        .COUNT_BITS (COUNT_BITS)
    ) u_frame_state (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_byte    (r_in_byte),
        .i_last    (r_in_last),
        .i_nonce   (r_nonce),
        .o_result  (result)
    );

    // Load a result on a last byte; drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out <= result;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_tag_found = r_out.tag_found;
    assign o_rule_id   = r_out.rule_id;
    assign o_status    = r_out.status;

`ifndef SYNTHESIS
    a_found_iff_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_tag_found == (o_status == ST_OK)))
        else $error("tag_found disagrees with status");

    a_id_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_tag_found) |-> (o_rule_id == 7'd0))
        else $error("rule id nonzero on failed frame");

    a_last_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in_last && o_valid && i_stall) |-> o_stall)
        else $error("last byte advanced over a held result");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_last) |=> o_valid)
        else $error("last byte gave no result");
`endif

endmodule

// ----- test/tptp_tag_checker.sv -----
// Checker for the tunnel policy tag parser: follows every accepted frame byte,
// predicts the per-frame result and compares it with what the block returns.
// Depends on tptp_pkg.
module tptp_tag_checker #(
    parameter int COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_stall_in,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic        i_res_valid,
    input  logic        i_res_stall,
    input  logic        i_tag_found,
    input  logic [6:0]  i_rule_id,
    input  logic [2:0]  i_status,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [6:0]  i_cfg_data,
    output int unsigned o_pending,
    output int unsigned o_errors
);
    import tptp_pkg::*;

    // Frame tracking state
    logic [COUNT_BITS-1:0] byte_idx;
    logic [15:0]           etype_seen;
    logic [3:0]            ihl_seen;
    logic [7:0]            proto_seen;
    logic [6:0]            tag_seen;
    logic                  tag_taken;
    logic [6:0]            nonce_len;

    t_result               expected_tags[$];
    t_result               want;
    int unsigned           errors = 0;

    task automatic clear_frame();
        byte_idx   = '0;
        etype_seen = '0;
        ihl_seen   = '0;
        proto_seen = '0;
        tag_seen   = '0;
        tag_taken  = 1'b0;
    endtask

    task automatic track_byte(input logic [7:0] value, input logic last);
        int unsigned idx;
        int unsigned tag_pos;
        int unsigned len;
        logic        past_hdr;
        t_status     st;
        idx      = int'(byte_idx);
        tag_pos  = 0;
        past_hdr = 1'b0;
        if (idx == POS_ETYPE_HI) etype_seen[15:8] = value;
        else if (idx == POS_ETYPE_LO) etype_seen[7:0] = value;
        if (idx == ETH_HDR) ihl_seen = value[3:0];

        if (etype_seen == ETYPE_IPV4) begin
            if (idx == POS_V4_PROTO) proto_seen = value;
            tag_pos  = ETH_HDR + int'(ihl_seen) * 4 + int'(nonce_len);
            past_hdr = idx > ETH_HDR;
        end else if (etype_seen == ETYPE_IPV6) begin
            if (idx == POS_V6_PROTO) proto_seen = value;
            tag_pos  = ETH_HDR + IPV6_HDR + int'(nonce_len);
            past_hdr = idx > ETH_HDR;
        end
        if (past_hdr && !tag_taken && idx == tag_pos) begin
            tag_seen  = value[6:0];
            tag_taken = 1'b1;
        end

        // saturate the index at its top value
        if (byte_idx != {COUNT_BITS{1'b1}}) byte_idx = byte_idx + 1'b1;

        if (last) begin
            len = idx + 1;
            if (len < MIN_FRAME)
                st = ST_SHORT;
            else if (etype_seen != ETYPE_IPV4 && etype_seen != ETYPE_IPV6)
                st = ST_BAD_ETYPE;
            else if (etype_seen == ETYPE_IPV4 && (int'(ihl_seen) * 4 < 20 ||
                     len < ETH_HDR + int'(ihl_seen) * 4 + 1))
                st = ST_BAD_HDR;
            else if (etype_seen == ETYPE_IPV6 && len < ETH_HDR + IPV6_HDR + 1)
                st = ST_BAD_HDR;
            else if (proto_seen != PROTO_MARK)
                st = ST_BAD_PROTO;
            else if (!tag_taken)
                st = ST_NO_TAG;
            else
                st = ST_OK;
            expected_tags.push_back('{tag_found: (st == ST_OK),
                                      rule_id:   (st == ST_OK) ? tag_seen : 7'd0,
                                      status:    st});
            clear_frame();
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_frame();
            nonce_len = NONCE_RESET;
            expected_tags.delete();
        end else begin
            // results first: none can belong to a byte taken at this same edge
            if (i_res_valid && !i_res_stall) begin
                if (expected_tags.size() == 0) begin
                    errors++;
                    $display("%0t: result with none expected: found %0d id %0d status %0d",
                             $time, i_tag_found, i_rule_id, i_status);
                end else begin
                    want = expected_tags.pop_front();
                    if (i_tag_found !== want.tag_found || i_rule_id !== want.rule_id ||
                        i_status !== want.status) begin
                        errors++;
                        $display("%0t: expected found %0d id %0d status %0d, got %0d %0d %0d",
                                 $time, want.tag_found, want.rule_id, want.status,
                                 i_tag_found, i_rule_id, i_status);
                    end
                end
            end
            if (i_valid && !i_stall_in) track_byte(i_data_byte, i_last_byte);
            if (i_cfg_valid && i_cfg_ready) nonce_len = i_cfg_data;
        end
        o_pending <= expected_tags.size();
        o_errors  <= errors;
    end

endmodule

// ----- test/tb_tunnel_policy_tag_parser_unit.sv -----
// Testbench top for the tunnel policy tag parser: drives frames byte by byte,
// stalls the result side and gives the verdict.
// Depends on tptp_pkg, tptp_tag_checker and the tunnel_policy_tag_parser_unit RTL.
module tb_tunnel_policy_tag_parser_unit;
    import tptp_pkg::*;

    localparam int          COUNT_BITS   = 8;          // narrow index so a long frame saturates it
    localparam int unsigned HOLD_LEN     = 400;        // long result hold-off, in cycles
    localparam int unsigned LIMIT_CYCLES = 200_000;
    localparam int unsigned LONG_FRAME   = 260;        // runs the byte index into saturation

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic [7:0] i_data_byte = 8'd0;
    logic       i_last_byte = 1'b0;
    logic       i_stall     = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic [6:0] i_cfg_data  = 7'd0;
    logic       o_stall;
    logic       o_valid;
    logic       o_tag_found;
    logic [6:0] o_rule_id;
    logic [2:0] o_status;
    logic       o_cfg_ready;

    int unsigned results_pending;
    int unsigned mismatch_count;

    // Idle shaping: the sender rate is used by the driver process only, the
    // receiver controls are changed with nonblocking writes so the receiver
    // process always sees a settled value at the edge.
    int unsigned send_idle_pct = 0;
    int unsigned rx_stall_pct  = 0;
    logic        hold_mode     = 1'b0;
    int unsigned hold_cnt      = 0;
    logic [6:0]  cur_nonce     = NONCE_RESET;

    tunnel_policy_tag_parser_unit #(
        .COUNT_BITS (COUNT_BITS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_tag_found (o_tag_found),
        .o_rule_id   (o_rule_id),
        .o_status    (o_status),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    tptp_tag_checker #(
        .COUNT_BITS (COUNT_BITS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_stall_in  (o_stall),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_res_valid (o_valid),
        .i_res_stall (i_stall),
        .i_tag_found (o_tag_found),
        .i_rule_id   (o_rule_id),
        .i_status    (o_status),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_pending   (results_pending),
        .o_errors    (mismatch_count)
    );

    always #5 i_clk = ~i_clk;

    // Result side: a long hold-off when asked for, counted here, and random
    // stalls at the current rate otherwise.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall  <= 1'b0;
            hold_cnt <= 0;
        end else if (hold_mode && hold_cnt < HOLD_LEN) begin
            i_stall  <= 1'b1;
            hold_cnt <= hold_cnt + 1;
        end else begin
            if (!hold_mode) hold_cnt <= 0;
            i_stall <= ($urandom_range(0, 99) < rx_stall_pct);
        end
    end

    // Offer one byte, with random idle cycles ahead of it, and hold it until taken.
    task automatic push_byte(input logic [7:0] value, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= value;
        i_last_byte <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // Send one frame: ethertype, version/IHL byte, protocol and tag byte at their
    // places, random bytes elsewhere. The header fields win over the tag position.
    task automatic send_frame(input logic [15:0] etype, input logic [7:0] ver_ihl,
                              input logic [7:0] proto, input int unsigned len,
                              input int unsigned tag_pos, input logic [7:0] tag);
        int unsigned proto_pos;
        logic [7:0]  value;
        proto_pos = (etype == ETYPE_IPV6) ? POS_V6_PROTO : POS_V4_PROTO;
        for (int unsigned k = 0; k < len; k++) begin
            if (k == POS_ETYPE_HI)      value = etype[15:8];
            else if (k == POS_ETYPE_LO) value = etype[7:0];
            else if (k == ETH_HDR)      value = ver_ihl;
            else if (k == proto_pos)    value = proto;
            else if (k == tag_pos)      value = tag;
            else                        value = 8'($urandom);
            push_byte(value, k == len - 1);
        end
    endtask

    // Drop valid and wait until every expected result is back, then let the
    // pipeline run dry before anything else touches the block.
    task automatic settle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (results_pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_nonce(input logic [6:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_nonce = value;
    endtask

    // Mostly well-formed tunnel frames with random content; the rest are cut
    // short, carry a wrong protocol, a bad IHL, an unknown ethertype, or are noise.
    task automatic random_frame(output int unsigned len);
        int unsigned pick;
        int unsigned ihl;
        int unsigned tag_pos;
        logic        v6;
        logic [15:0] etype;
        logic [7:0]  proto;
        pick    = $urandom_range(0, 99);
        v6      = ($urandom_range(0, 2) == 0);
        ihl     = (pick >= 78 && pick < 86) ? $urandom_range(0, 4) : $urandom_range(5, 15);
        etype   = v6 ? ETYPE_IPV6 : ETYPE_IPV4;
        proto   = PROTO_MARK;
        tag_pos = ETH_HDR + (v6 ? IPV6_HDR : ihl * 4) + cur_nonce;
        len     = tag_pos + 1 + $urandom_range(0, 6);
        if (pick >= 60 && pick < 70) begin
            // end the frame shortly before the tag byte
            len = $urandom_range(tag_pos > 24 ? tag_pos - 24 : 1, tag_pos);
        end else if (pick >= 70 && pick < 78) begin
            proto = 8'($urandom);
        end else if (pick >= 86 && pick < 92) begin
            etype = 16'($urandom);
        end else if (pick >= 92) begin
            etype = 16'($urandom);
            proto = 8'($urandom);
            len   = $urandom_range(1, 80);
        end
        send_frame(etype, {4'($urandom), 4'(ihl)}, proto, len, tag_pos, 8'($urandom));
    endtask

    // One random phase at a given nonce length and idle pattern.
    task automatic run_phase(input int unsigned send_pct, input int unsigned rx_pct,
                             input logic [6:0] nonce, input logic hold);
        int unsigned bytes_sent;
        int unsigned frames_sent;
        int unsigned len;
        write_nonce(nonce);
        send_idle_pct = send_pct;
        rx_stall_pct <= rx_pct;
        hold_mode    <= hold;
        bytes_sent  = 0;
        frames_sent = 0;
        while (bytes_sent < 100 || frames_sent < 2) begin
            random_frame(len);
            bytes_sent += len;
            frames_sent++;
            // now and then pause until every result is back
            if ($urandom_range(0, 15) == 0) settle();
        end
        settle();
        hold_mode <= 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset nonce of 16: the tag sits at byte 50 behind a minimal IPv4
        // header and at byte 70 behind IPv6.
        send_frame(ETYPE_IPV4, 8'h45, PROTO_MARK, 51, 50, 8'hFF);  // tag last, top bit dropped
        send_frame(ETYPE_IPV4, 8'h45, PROTO_MARK, 1, 50, 8'h00);   // single-byte frame
        send_frame(ETYPE_IPV4, 8'h45, PROTO_MARK, 33, 50, 8'h00);  // one below minimum
        send_frame(ETYPE_IPV4, 8'h45, PROTO_MARK, 34, 50, 8'h00);  // minimum, no tag
        send_frame(16'h0801, 8'h45, PROTO_MARK, 34, 50, 8'h11);    // unknown ethertype
        send_frame(ETYPE_IPV4, 8'h44, PROTO_MARK, 34, 46, 8'h22);  // IHL below 5
        send_frame(ETYPE_IPV4, 8'h4F, PROTO_MARK, 74, 90, 8'h33);  // header cut short
        send_frame(ETYPE_IPV4, 8'h4F, PROTO_MARK, 75, 90, 8'h33);  // header just fits
        send_frame(ETYPE_IPV6, 8'h60, PROTO_MARK, 54, 70, 8'h44);  // IPv6 header short
        send_frame(ETYPE_IPV6, 8'h60, PROTO_MARK, 55, 70, 8'h44);  // IPv6 header fits
        send_frame(ETYPE_IPV4, 8'h45, PROTO_MARK - 8'd1, 35, 50, 8'h55);  // wrong protocol
        settle();

        // Zero nonce: tag right behind the IP header; with IHL 0 the tag
        // position falls on the IHL byte itself and must not be taken.
        write_nonce(7'd0);
        send_frame(ETYPE_IPV4, 8'h45, PROTO_MARK, 35, 34, 8'h00);
        send_frame(ETYPE_IPV4, 8'h40, PROTO_MARK, 34, 14, 8'h77);
        settle();

        // Largest nonce: furthest tag position, in a frame long enough to
        // saturate the byte index.
        write_nonce(7'h7F);
        send_frame(ETYPE_IPV4, 8'h4F, PROTO_MARK, LONG_FRAME, 201, 8'hA5);
        settle();

        // Random phases: no idling, sender idle, receiver stalling, both
        // lightly, and a long result hold-off that backs the block up.
        run_phase(0, 0, 7'd4, 1'b0);
        run_phase(72, 0, 7'd0, 1'b0);
        run_phase(0, 72, 7'd8, 1'b0);
        run_phase(8, 8, 7'($urandom_range(0, 8)), 1'b0);
        run_phase(0, 0, 7'd0, 1'b1);

        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Hard stop if the run hangs, e.g. on a result that never comes.
    initial begin
        #(LIMIT_CYCLES * 10);
        $display("FAILURE");
        $finish;
    end

endmodule
